FILE: src/osq_pkg.sv
`timescale 1ns / 1ps
// Package for the oriented square overlap test.
// Holds trig polynomial constants, stage count and shared helper functions.
package osq_pkg;

  localparam int NSTAGE = 12;

  localparam logic signed [32:0] TRIG_C1 = 33'sd1686629713;
  localparam logic signed [32:0] TRIG_C3 = 33'sd693598669;
  localparam logic signed [32:0] TRIG_C5 = 33'sd85569306;
  localparam logic signed [32:0] TRIG_C7 = 33'sd5026995;
  localparam logic signed [32:0] TRIG_C9 = 33'sd172272;
  localparam logic [22:0] QUARTER_ONE = 23'd4194304;

  typedef struct packed {
    logic signed [20:0] dx;
    logic signed [20:0] dy;
    logic [15:0]        side_a;
    logic [15:0]        side_b;
  } osq_geom_t;

  // one Horner step: floor(p * t2 / 2^22) + c
  function automatic logic signed [32:0] horner(input logic signed [32:0] p,
                                                input logic [22:0] t2,
                                                input logic signed [32:0] c);
    logic signed [56:0] m;
    m = p * $signed({1'b0, t2});
    return m[54:22] + c;
  endfunction

  // round Q30 to Q15 and clamp to 0..32768
  function automatic logic signed [16:0] round_q15(input logic signed [32:0] s);
    logic signed [33:0] r;
    r = ($signed({s[32], s}) + 34'sd16384) >>> 15;
    if (r < 34'sd0) return 17'sd0;
    else if (r > 34'sd32768) return 17'sd32768;
    else return r[16:0];
  endfunction

endpackage

FILE: src/osq_sine.sv
`timescale 1ns / 1ps
// Quarter-wave sine pipeline, six register stages of Horner evaluation.
// Depends on osq_pkg.
module osq_sine import osq_pkg::*; (
  input  logic                clk,
  input  logic [5:0]          en,
  input  logic [22:0]         t,
  output logic signed [32:0]  s_r
);

  logic [22:0]        t2_r [1:4];
  logic [22:0]        tc_r [1:5];
  logic signed [32:0] p_r  [2:5];
  logic [45:0]        sq;
  logic signed [56:0] m6;

  assign sq = t * t;
  assign m6 = p_r[5] * $signed({1'b0, tc_r[5]});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t2_r[1] <= sq[44:22];
      tc_r[1] <= t;
    end
    if (en[1]) begin
      p_r[2]  <= horner(TRIG_C9, t2_r[1], -TRIG_C7);
      t2_r[2] <= t2_r[1];
      tc_r[2] <= tc_r[1];
    end
    if (en[2]) begin
      p_r[3]  <= horner(p_r[2], t2_r[2], TRIG_C5);
      t2_r[3] <= t2_r[2];
      tc_r[3] <= tc_r[2];
    end
    if (en[3]) begin
      p_r[4]  <= horner(p_r[3], t2_r[3], -TRIG_C3);
      t2_r[4] <= t2_r[3];
      tc_r[4] <= tc_r[3];
    end
    if (en[4]) begin
      p_r[5]  <= horner(p_r[4], t2_r[4], TRIG_C1);
      tc_r[5] <= tc_r[4];
    end
    if (en[5]) begin
      s_r <= m6[54:22];
    end
  end

endmodule

FILE: src/osq_trig.sv
`timescale 1ns / 1ps
// Cosine/sine generator: phase split, two quarter-sine pipelines, quadrant map.
// Depends on osq_pkg and osq_sine.
module osq_trig import osq_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk,
  input  logic [7:0]         en,
  input  logic [15:0]        angle,
  output logic signed [16:0] cos_r,
  output logic signed [16:0] sin_r
);

  localparam logic [23:0] KEEP = ~((24'd1 << (24 - ANGLE_BITS)) - 24'd1);

  logic [23:0]        phase;
  logic [22:0]        t_r;
  logic [22:0]        u_r;
  logic [1:0]         quad_r [0:6];
  logic signed [32:0] st_s;
  logic signed [32:0] su_s;
  logic signed [16:0] rt;
  logic signed [16:0] ru;

  assign phase = {angle, 8'd0} & KEEP;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t_r       <= {1'b0, phase[21:0]};
      u_r       <= QUARTER_ONE - {1'b0, phase[21:0]};
      quad_r[0] <= phase[23:22];
    end
    for (int i = 1; i <= 6; i++) begin
      if (en[i]) quad_r[i] <= quad_r[i-1];
    end
  end

  osq_sine u_sine_t (.clk(clk), .en(en[6:1]), .t(t_r), .s_r(st_s));
  osq_sine u_sine_u (.clk(clk), .en(en[6:1]), .t(u_r), .s_r(su_s));

  assign rt = round_q15(st_s);
  assign ru = round_q15(su_s);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      unique case (quad_r[6])
        2'd0: begin cos_r <= ru;  sin_r <= rt;  end
        2'd1: begin cos_r <= -rt; sin_r <= ru;  end
        2'd2: begin cos_r <= -ru; sin_r <= -rt; end
        default: begin cos_r <= rt; sin_r <= -ru; end
      endcase
    end
  end

endmodule

FILE: src/osq_axis.sv
`timescale 1ns / 1ps
// Separating axis stages: products, projections, side bounds, compare.
// Depends on osq_pkg.
module osq_axis import osq_pkg::*; (
  input  logic               clk,
  input  logic [3:0]         en,
  input  logic signed [16:0] ca,
  input  logic signed [16:0] sa,
  input  logic signed [16:0] cb,
  input  logic signed [16:0] sb,
  input  osq_geom_t          geom,
  output logic               hit_r
);

  logic signed [33:0] pcc_r, pss_r, pcs_r, psc_r;
  logic signed [37:0] xca_r, ysa_r, yca_r, xsa_r, xcb_r, ysb_r, ycb_r, xsb_r;
  logic [15:0]        sa1_r, sb1_r, sa2_r, sb2_r, sa3_r, sb3_r;
  logic [31:0]        k_r;
  logic [36:0]        pj_r  [0:3];
  logic [36:0]        pj3_r [0:3];
  logic [47:0]        ka_r, kb_r;

  logic signed [34:0] k1, k2;
  logic signed [38:0] q [0:3];
  logic [53:0]        lhs [0:3];
  logic [53:0]        rhs_a, rhs_b;

  always_comb begin
    k1   = $signed({pcc_r[33], pcc_r}) + $signed({pss_r[33], pss_r});
    k2   = $signed({pcs_r[33], pcs_r}) - $signed({psc_r[33], psc_r});
    q[0] = $signed({xca_r[37], xca_r}) + $signed({ysa_r[37], ysa_r});
    q[1] = $signed({yca_r[37], yca_r}) - $signed({xsa_r[37], xsa_r});
    q[2] = $signed({xcb_r[37], xcb_r}) + $signed({ysb_r[37], ysb_r});
    q[3] = $signed({ycb_r[37], ycb_r}) - $signed({xsb_r[37], xsb_r});
    for (int i = 0; i < 4; i++) lhs[i] = {1'b0, pj3_r[i], 16'd0};
    rhs_a = {8'd0, sa3_r, 30'd0} + {6'd0, kb_r};
    rhs_b = {8'd0, sb3_r, 30'd0} + {6'd0, ka_r};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pcc_r <= ca * cb;
      pss_r <= sa * sb;
      pcs_r <= ca * sb;
      psc_r <= sa * cb;
      xca_r <= geom.dx * ca;
      ysa_r <= geom.dy * sa;
      yca_r <= geom.dy * ca;
      xsa_r <= geom.dx * sa;
      xcb_r <= geom.dx * cb;
      ysb_r <= geom.dy * sb;
      ycb_r <= geom.dy * cb;
      xsb_r <= geom.dx * sb;
      sa1_r <= geom.side_a;
      sb1_r <= geom.side_b;
    end
    if (en[1]) begin
      k_r <= 32'(k1 < 0 ? -k1 : k1) + 32'(k2 < 0 ? -k2 : k2);
      for (int i = 0; i < 4; i++) pj_r[i] <= 37'(q[i] < 0 ? -q[i] : q[i]);
      sa2_r <= sa1_r;
      sb2_r <= sb1_r;
    end
    if (en[2]) begin
      ka_r  <= sa2_r * k_r;
      kb_r  <= sb2_r * k_r;
      pj3_r <= pj_r;
      sa3_r <= sa2_r;
      sb3_r <= sb2_r;
    end
    if (en[3]) begin
      hit_r <= (lhs[0] <= rhs_a) && (lhs[1] <= rhs_a) &&
               (lhs[2] <= rhs_b) && (lhs[3] <= rhs_b);
    end
  end

endmodule

FILE: src/oriented_square_overlap_test.sv
`timescale 1ns / 1ps
// Top level of the oriented square overlap test (separating axis test).
// Depends on osq_pkg, osq_trig, osq_axis.
//
// channel | dir | ports              | word
// in      | in  | in_tvalid/tready   | two squares: centre, angle, side
// out     | out | out_tvalid/tready  | overlap flag
//
// One pair per cycle while the output is not stalled; 12 stages plus output register.
// The four-step Horner sine chain and the two product stages set the depth.
// Reset (rst_n low, synchronous) clears all stage valid bits.
// A stall holds only the stages that are full; bubbles close up.
module oriented_square_overlap_test import osq_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // a_x[19:0] a_y[39:20] a_angle[55:40] a_side[71:56]
  // b_x[91:72] b_y[111:92] b_angle[127:112] b_side[143:128]
  input  logic [143:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // overlap[0], zero fill [7:1]
  output logic [7:0]   out_tdata
);

  logic [NSTAGE-1:0] v_r;
  logic [NSTAGE:0]   ld;
  logic              out_tvalid_r;
  logic              overlap_r;
  osq_geom_t         g_r [0:7];
  logic signed [16:0] ca, sa, cb, sb;
  logic              hit;

  always_comb begin
    ld[NSTAGE] = !out_tvalid_r || out_tready;
    for (int i = NSTAGE - 1; i >= 0; i--) ld[i] = !v_r[i] || ld[i+1];
  end

  assign in_tready  = ld[0];
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, overlap_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r          <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (ld[0]) v_r[0] <= in_tvalid;
      for (int i = 1; i < NSTAGE; i++) begin
        if (ld[i]) v_r[i] <= v_r[i-1];
      end
      if (ld[NSTAGE]) out_tvalid_r <= v_r[NSTAGE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      g_r[0].dx     <= {in_tdata[91], in_tdata[91:72]} - {in_tdata[19], in_tdata[19:0]};
      g_r[0].dy     <= {in_tdata[111], in_tdata[111:92]} - {in_tdata[39], in_tdata[39:20]};
      g_r[0].side_a <= in_tdata[71:56];
      g_r[0].side_b <= in_tdata[143:128];
    end
    for (int i = 1; i <= 7; i++) begin
      if (ld[i]) g_r[i] <= g_r[i-1];
    end
    if (ld[NSTAGE]) overlap_r <= hit;
  end

  osq_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_a (
    .clk(clk), .en(ld[7:0]), .angle(in_tdata[55:40]), .cos_r(ca), .sin_r(sa)
  );
  osq_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_b (
    .clk(clk), .en(ld[7:0]), .angle(in_tdata[127:112]), .cos_r(cb), .sin_r(sb)
  );

  osq_axis u_axis (
    .clk(clk), .en(ld[11:8]), .ca(ca), .sa(sa), .cb(cb), .sb(sb),
    .geom(g_r[7]), .hit_r(hit)
  );

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v_r[0])
    else $error("accepted word did not enter stage 0");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r) && out_tvalid_r && !out_tready |-> !in_tready)
    else $error("input accepted while pipeline full and stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (v_r == '0) && !out_tvalid_r)
    else $error("reset left valid bits set");

  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NSTAGE-1] && ld[NSTAGE] |=> out_tvalid_r)
    else $error("last stage word lost");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for oriented_square_overlap_test: streams square pairs through the
// block and checks each overlap flag against a local separating axis predictor.
// Depends on oriented_square_overlap_test.
module tb;

  localparam int ANGLE_BITS = 16;
  localparam int NUM_RANDOM = 1650;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [15:0] b_side;
    logic [15:0] b_angle;
    logic [19:0] b_y;
    logic [19:0] b_x;
    logic [15:0] a_side;
    logic [15:0] a_angle;
    logic [19:0] a_y;
    logic [19:0] a_x;
  } square_pair_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [143:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [7:0]   out_tdata;

  square_pair_t pending_pairs[$];
  bit           expected_hits[$];
  bit           drive_on = 1'b0;
  int           errors = 0;
  int           idle_cycles = 0;
  int           cycle_count = 0;
  int           hold_off = 0;

  oriented_square_overlap_test #(.ANGLE_BITS(ANGLE_BITS)) dut (.*);

  always #4 clk = ~clk;

  function automatic longint floor_div22(longint v);
    return v >>> 22;
  endfunction

  function automatic longint quarter_sin(longint t);
    longint t2, p, r;
    t2 = floor_div22(t * t);
    p = 172272;
    p = floor_div22(p * t2) - 5026995;
    p = floor_div22(p * t2) + 85569306;
    p = floor_div22(p * t2) - 693598669;
    p = floor_div22(p * t2) + 1686629713;
    r = (floor_div22(p * t) + 16384) >>> 15;
    if (r < 0) r = 0;
    if (r > 32768) r = 32768;
    return r;
  endfunction

  function automatic void rotation(input logic [15:0] angle, output longint c,
                                   output longint s);
    logic [23:0] phase;
    longint t, st, su;
    phase = {angle, 8'h00} & ~((24'd1 << (24 - ANGLE_BITS)) - 24'd1);
    t = longint'(phase[21:0]);
    st = quarter_sin(t);
    su = quarter_sin(64'd4194304 - t);
    case (phase[23:22])
      2'd0: begin c = su; s = st; end
      2'd1: begin c = -st; s = su; end
      2'd2: begin c = -su; s = -st; end
      default: begin c = st; s = -su; end
    endcase
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic bit projections_meet(longint proj, longint own, longint other,
                                          longint ksum);
    return mag(proj) * 65536 <= own * 64'd1073741824 + other * ksum;
  endfunction

  function automatic bit squares_overlap(square_pair_t p);
    longint dx, dy, sa_len, sb_len, ca, sa, cb, sb, ksum;
    dx = longint'($signed(p.b_x)) - longint'($signed(p.a_x));
    dy = longint'($signed(p.b_y)) - longint'($signed(p.a_y));
    sa_len = longint'(p.a_side);
    sb_len = longint'(p.b_side);
    rotation(p.a_angle, ca, sa);
    rotation(p.b_angle, cb, sb);
    ksum = mag(ca * cb + sa * sb) + mag(ca * sb - sa * cb);
    return projections_meet(dx * ca + dy * sa, sa_len, sb_len, ksum)
        && projections_meet(dy * ca - dx * sa, sa_len, sb_len, ksum)
        && projections_meet(dx * cb + dy * sb, sb_len, sa_len, ksum)
        && projections_meet(dy * cb - dx * sb, sb_len, sa_len, ksum);
  endfunction

  function automatic logic [19:0] near_coord(logic [19:0] base);
    return base + 20'($signed(13'($urandom)));
  endfunction

  function automatic square_pair_t random_pair();
    square_pair_t p;
    p = square_pair_t'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    case ($urandom_range(0, 3))
      0: ;
      1: begin
        p.a_side = 16'($urandom_range(0, 4095));
        p.b_side = 16'($urandom_range(0, 4095));
        p.b_x = near_coord(p.a_x);
        p.b_y = near_coord(p.a_y);
      end
      default: begin
        p.b_x = p.a_x + 20'($signed(18'($urandom)));
        p.b_y = p.a_y + 20'($signed(18'($urandom)));
      end
    endcase
    return p;
  endfunction

  function automatic bit idle_roll(int cyc);
    return (cyc < 300 || cyc >= 800) && $urandom_range(0, 99) < 32;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_hits.push_back(squares_overlap(square_pair_t'(in_tdata)));
      end
      if (!in_tvalid || in_tready) begin
        if (drive_on && pending_pairs.size() != 0 && !idle_roll(cycle_count)) begin
          in_tvalid <= 1'b1;
          in_tdata <= pending_pairs.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_hits.size() == 0) begin
          $error("overlap: unexpected word, actual %0d", out_tdata[0]);
          errors <= errors + 1;
        end else begin
          automatic bit exp_hit = expected_hits.pop_front();
          if (out_tdata[0] !== exp_hit) begin
            $error("overlap: expected %0d actual %0d", exp_hit, out_tdata[0]);
            errors <= errors + 1;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_tready <= 1'b0;
      end else if (cycle_count == 450) begin
        hold_off <= 200;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !idle_roll(cycle_count);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    square_pair_t p;
    logic [19:0] cmax, cmin;
    cmax = 20'h7FFFF;
    cmin = 20'h80000;
    p = '0;
    pending_pairs.push_back(p);
    p.a_side = 16'hFFFF; p.b_side = 16'hFFFF;
    p.a_angle = 16'hFFFF; p.b_angle = 16'h2000;
    pending_pairs.push_back(p);
    p = '0; p.a_x = cmax; p.a_y = cmax; p.b_x = cmin; p.b_y = cmin;
    p.a_side = 16'hFFFF; p.b_side = 16'hFFFF;
    pending_pairs.push_back(p);
    p = '0; p.a_x = cmin; p.b_x = cmax; p.a_angle = 16'h4000; p.b_angle = 16'h8000;
    pending_pairs.push_back(p);
    // touching edges: side 256 units each, centres 256 units apart
    p = '0; p.a_side = 16'd256; p.b_side = 16'd256; p.b_x = 20'd256;
    pending_pairs.push_back(p);
    p.b_x = 20'd257;
    pending_pairs.push_back(p);
    p.b_x = 20'd256; p.a_angle = 16'hC000; p.b_angle = 16'h4000;
    pending_pairs.push_back(p);
    p = '0; p.a_side = 16'd256; p.b_side = 16'd0; p.b_x = 20'd128;
    pending_pairs.push_back(p);
    p.b_x = 20'd129;
    pending_pairs.push_back(p);
    p = '0; p.a_side = 16'd256; p.b_side = 16'd256;
    p.a_angle = 16'h2000; p.b_angle = 16'h6000; p.b_x = 20'd362; p.b_y = 20'd0;
    pending_pairs.push_back(p);
    p.b_x = 20'd363;
    pending_pairs.push_back(p);
    p.a_angle = 16'h1000; p.b_angle = 16'hF000; p.b_x = 20'hFFF00; p.b_y = 20'd100;
    pending_pairs.push_back(p);
    for (int i = 0; i < NUM_RANDOM; i++) pending_pairs.push_back(random_pair());

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    drive_on <= 1'b1;
    wait (pending_pairs.size() == 0 && !in_tvalid);
    wait (expected_hits.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_hits.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
